// ----- src/assert_macros.svh -----
// assert_macros.svh: concurrent assertion helpers shared by the RTL.
// No dependencies; take in by include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CSL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define CSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/csl_pkg.sv -----
// csl_pkg: shared constants, register indexes and state types of the line clipper.
// No dependencies; imported by csl_muldiv and cohen_sutherland_line_clip_top.
`timescale 1ns / 1ps

package csl_pkg;

   localparam int FRACTION_BITS_DEF = 8;
   localparam int COORD_BITS_DEF    = 16;

   // Clip passes before a segment is given up as rejected
   localparam int MAX_PASSES = 8;
   localparam int PASS_BITS  = $clog2(MAX_PASSES + 1);

   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LEFT   = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_BOTTOM = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_RIGHT  = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_TOP    = 4'd3;

   localparam int WIN_LEFT_RESET   = 250;
   localparam int WIN_BOTTOM_RESET = 250;
   localparam int WIN_RIGHT_RESET  = 750;
   localparam int WIN_TOP_RESET    = 750;

   // Outcode bits
   localparam logic [3:0] CODE_LEFT   = 4'b0001;
   localparam logic [3:0] CODE_RIGHT  = 4'b0010;
   localparam logic [3:0] CODE_BOTTOM = 4'b0100;
   localparam logic [3:0] CODE_TOP    = 4'b1000;

   typedef enum logic [1:0] {
      S_IDLE,
      S_TEST,
      S_WAIT
   } csl_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

endpackage

// ----- src/csl_muldiv.sv -----
// csl_muldiv: sequential signed (a * b) / d, truncated toward zero, on one shared adder.
// Depends on csl_pkg (md_state_type).
`timescale 1ns / 1ps

module csl_muldiv import csl_pkg::*; #(
   parameter int WIDTH = COORD_BITS_DEF + FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [WIDTH:0]   num_a,
   input  logic signed [WIDTH:0]   num_b,
   input  logic signed [WIDTH:0]   den,
   output logic                    done,
   output logic signed [WIDTH:0]   quotient
);

   localparam int CNT_BITS = $clog2(WIDTH);

   md_state_type          state_ff, state_in;
   logic [WIDTH-1:0]      hi_ff, hi_in;
   logic [WIDTH-1:0]      lo_ff, lo_in;
   logic [WIDTH-1:0]      mcand_ff, mcand_in;
   logic [WIDTH-1:0]      den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic [WIDTH:0]        abs_a, abs_b, abs_d;
   logic [WIDTH:0]        add_a, add_b;
   logic                  add_sub;
   logic [WIDTH+1:0]      add_res;

   assign abs_a = num_a[WIDTH] ? -num_a : num_a;
   assign abs_b = num_b[WIDTH] ? -num_b : num_b;
   assign abs_d = den[WIDTH] ? -den : den;

   // shared adder; in subtract mode the top bit set means a < b
   assign add_res = {1'b0, add_a} + ({1'b0, add_b} ^ {(WIDTH + 2){add_sub}})
                    + (WIDTH + 2)'(add_sub);

   assign quotient = neg_ff ? -{1'b0, lo_ff} : {1'b0, lo_ff};

   always_comb begin
      state_in = state_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      add_a    = '0;
      add_b    = '0;
      add_sub  = 1'b0;
      done     = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               hi_in    = '0;
               lo_in    = abs_b[WIDTH-1:0];
               mcand_in = abs_a[WIDTH-1:0];
               den_in   = abs_d[WIDTH-1:0];
               neg_in   = num_a[WIDTH] ^ num_b[WIDTH] ^ den[WIDTH];
               cnt_in   = CNT_BITS'(WIDTH - 1);
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            // shift-add: {hi, lo} ends up holding the 2*WIDTH-bit product
            add_a = {1'b0, hi_ff};
            add_b = lo_ff[0] ? {1'b0, mcand_ff} : '0;
            hi_in = add_res[WIDTH:1];
            lo_in = {add_res[0], lo_ff[WIDTH-1:1]};
            if (cnt_ff == '0) begin
               cnt_in   = CNT_BITS'(WIDTH - 1);
               state_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DIV: begin
            // restoring division, quotient bits shift into lo
            add_a   = {hi_ff, lo_ff[WIDTH-1]};
            add_b   = {1'b0, den_ff};
            add_sub = 1'b1;
            if (!add_res[WIDTH+1]) begin
               hi_in = add_res[WIDTH-1:0];
            end else begin
               hi_in = add_a[WIDTH-1:0];
            end
            lo_in = {lo_ff[WIDTH-2:0], ~add_res[WIDTH+1]};
            if (cnt_ff == '0) begin
               state_in = MD_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DONE: begin
            done     = 1'b1;
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
   end

endmodule

// ----- src/cohen_sutherland_line_clip_top.sv -----
// Cohen-Sutherland line clipper, one segment per request beat, window set via csr_ writes.
// A segment is taken in S_IDLE, checked once per clip pass, and each pass moves one
// endpoint onto a window edge using the shared multiply/divide unit in csl_muldiv: WIDTH
// shift-add steps, then WIDTH restoring-division steps, WIDTH = COORD_BITS + FRACTION_BITS.
// A segment takes 0 to 8 clip passes, and at the default Q16.8 WIDTH is 24. req_stall
// stays high while a segment is in work; a finished result waits in the output register
// and the next segment can be taken meanwhile. Depends on csl_pkg, csl_muldiv and
// assert_macros.svh.
`timescale 1ns / 1ps

module cohen_sutherland_line_clip_top import csl_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,

   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [COORD_BITS-1:0]               req_start_x,
   input  logic signed [COORD_BITS-1:0]               req_start_y,
   input  logic signed [COORD_BITS-1:0]               req_end_x,
   input  logic signed [COORD_BITS-1:0]               req_end_y,

   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_accepted,
   output logic signed [COORD_BITS+FRACTION_BITS-1:0] rsp_clipped_start_x,
   output logic signed [COORD_BITS+FRACTION_BITS-1:0] rsp_clipped_start_y,
   output logic signed [COORD_BITS+FRACTION_BITS-1:0] rsp_clipped_end_x,
   output logic signed [COORD_BITS+FRACTION_BITS-1:0] rsp_clipped_end_y,

   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]                  csr_index,
   input  logic signed [COORD_BITS-1:0]               csr_data
);

`include "assert_macros.svh"

   localparam int W = COORD_BITS + FRACTION_BITS;

   function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                          input logic signed [W-1:0] y,
                                          input logic signed [W-1:0] l,
                                          input logic signed [W-1:0] b,
                                          input logic signed [W-1:0] r,
                                          input logic signed [W-1:0] t);
      logic [3:0] c;
      c = '0;
      if (x < l) begin
         c = c | CODE_LEFT;
      end else if (x > r) begin
         c = c | CODE_RIGHT;
      end
      if (y < b) begin
         c = c | CODE_BOTTOM;
      end else if (y > t) begin
         c = c | CODE_TOP;
      end
      return c;
   endfunction

   logic signed [COORD_BITS-1:0] win_left_ff, win_bottom_ff, win_right_ff, win_top_ff;
   logic signed [W-1:0]          win_l_fx, win_b_fx, win_r_fx, win_t_fx;

   csl_state_type                state_ff, state_in;
   logic [PASS_BITS-1:0]         pass_ff, pass_in;
   logic signed [W-1:0]          x1_ff, x1_in, y1_ff, y1_in;
   logic signed [W-1:0]          x2_ff, x2_in, y2_ff, y2_in;
   logic signed [W-1:0]          edge_ff, edge_in;
   logic                         axis_y_ff, axis_y_in;
   logic                         move2_ff, move2_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_acc_ff, rsp_acc_in;
   logic signed [W-1:0]          rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;
   logic signed [W-1:0]          rsp_ex_ff, rsp_ex_in, rsp_ey_ff, rsp_ey_in;

   logic [3:0]                   c1, c2, co;
   logic                         all_in, give_up, can_emit;
   logic                         sel_y;
   logic signed [W-1:0]          sel_edge;
   logic signed [W:0]            dx, dy, de_x, de_y;
   logic signed [W:0]            md_a, md_b, md_d;
   logic                         md_start, md_done;
   logic signed [W:0]            md_quot;
   logic signed [W:0]            new_sum;
   logic signed [W-1:0]          new_x, new_y;

   assign win_l_fx = $signed(W'(win_left_ff)) <<< FRACTION_BITS;
   assign win_b_fx = $signed(W'(win_bottom_ff)) <<< FRACTION_BITS;
   assign win_r_fx = $signed(W'(win_right_ff)) <<< FRACTION_BITS;
   assign win_t_fx = $signed(W'(win_top_ff)) <<< FRACTION_BITS;

   assign c1 = outcode(x1_ff, y1_ff, win_l_fx, win_b_fx, win_r_fx, win_t_fx);
   assign c2 = outcode(x2_ff, y2_ff, win_l_fx, win_b_fx, win_r_fx, win_t_fx);
   assign co = (c1 != '0) ? c1 : c2;

   assign all_in   = (c1 | c2) == '0;
   assign give_up  = ((c1 & c2) != '0) || (pass_ff == PASS_BITS'(MAX_PASSES));
   assign can_emit = !rsp_valid_ff || !rsp_stall;

   // edge order: top, bottom, right, left
   always_comb begin
      if ((co & CODE_TOP) != '0) begin
         sel_y    = 1'b1;
         sel_edge = win_t_fx;
      end else if ((co & CODE_BOTTOM) != '0) begin
         sel_y    = 1'b1;
         sel_edge = win_b_fx;
      end else if ((co & CODE_RIGHT) != '0) begin
         sel_y    = 1'b0;
         sel_edge = win_r_fx;
      end else begin
         sel_y    = 1'b0;
         sel_edge = win_l_fx;
      end
   end

   // interpolation is always based on the first endpoint, whichever one moves
   assign dx   = (W + 1)'(x2_ff) - (W + 1)'(x1_ff);
   assign dy   = (W + 1)'(y2_ff) - (W + 1)'(y1_ff);
   assign de_x = (W + 1)'(sel_edge) - (W + 1)'(x1_ff);
   assign de_y = (W + 1)'(sel_edge) - (W + 1)'(y1_ff);
   assign md_a = sel_y ? dx : dy;
   assign md_b = sel_y ? de_y : de_x;
   assign md_d = sel_y ? dy : dx;

   csl_muldiv #(
      .WIDTH    (W)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .num_a    (md_a),
      .num_b    (md_b),
      .den      (md_d),
      .done     (md_done),
      .quotient (md_quot)
   );

   assign new_sum = (axis_y_ff ? (W + 1)'(x1_ff) : (W + 1)'(y1_ff)) + md_quot;
   assign new_x   = axis_y_ff ? new_sum[W-1:0] : edge_ff;
   assign new_y   = axis_y_ff ? edge_ff : new_sum[W-1:0];

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      edge_in      = edge_ff;
      axis_y_in    = axis_y_ff;
      move2_in     = move2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      rsp_sx_in    = rsp_sx_ff;
      rsp_sy_in    = rsp_sy_ff;
      rsp_ex_in    = rsp_ex_ff;
      rsp_ey_in    = rsp_ey_ff;
      md_start     = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               x1_in    = $signed(W'(req_start_x)) <<< FRACTION_BITS;
               y1_in    = $signed(W'(req_start_y)) <<< FRACTION_BITS;
               x2_in    = $signed(W'(req_end_x)) <<< FRACTION_BITS;
               y2_in    = $signed(W'(req_end_y)) <<< FRACTION_BITS;
               pass_in  = '0;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (all_in || give_up) begin
               // hold here until the output register is free
               if (can_emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_acc_in   = all_in;
                  rsp_sx_in    = all_in ? x1_ff : '0;
                  rsp_sy_in    = all_in ? y1_ff : '0;
                  rsp_ex_in    = all_in ? x2_ff : '0;
                  rsp_ey_in    = all_in ? y2_ff : '0;
                  state_in     = S_IDLE;
               end
            end else begin
               md_start  = 1'b1;
               edge_in   = sel_edge;
               axis_y_in = sel_y;
               move2_in  = (c1 == '0);
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (md_done) begin
               if (move2_ff) begin
                  x2_in = new_x;
                  y2_in = new_y;
               end else begin
                  x1_in = new_x;
                  y1_in = new_y;
               end
               pass_in  = pass_ff + 1'b1;
               state_in = S_TEST;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      edge_ff    <= edge_in;
      axis_y_ff  <= axis_y_in;
      move2_ff   <= move2_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_sx_ff  <= rsp_sx_in;
      rsp_sy_ff  <= rsp_sy_in;
      rsp_ex_ff  <= rsp_ex_in;
      rsp_ey_ff  <= rsp_ey_in;
   end

   // window registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= COORD_BITS'(WIN_LEFT_RESET);
         win_bottom_ff <= COORD_BITS'(WIN_BOTTOM_RESET);
         win_right_ff  <= COORD_BITS'(WIN_RIGHT_RESET);
         win_top_ff    <= COORD_BITS'(WIN_TOP_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   win_left_ff   <= csr_data;
            CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_data;
            CSR_WINDOW_RIGHT:  win_right_ff  <= csr_data;
            CSR_WINDOW_TOP:    win_top_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_clipped_start_x = rsp_sx_ff;
   assign rsp_clipped_start_y = rsp_sy_ff;
   assign rsp_clipped_end_x   = rsp_ex_ff;
   assign rsp_clipped_end_y   = rsp_ey_ff;

   `CSL_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid_ff && !rsp_acc_ff,
      rsp_sx_ff == '0 && rsp_sy_ff == '0 && rsp_ex_ff == '0 && rsp_ey_ff == '0)
   `CSL_ASSERT_IMP(a_done_in_wait, clock, reset, md_done, state_ff == S_WAIT)
   `CSL_ASSERT(a_pass_bound, clock, reset, pass_ff <= PASS_BITS'(MAX_PASSES))

endmodule
